[hw/rtl/scol_pkg.sv]
`default_nettype none
package scol_pkg;

  typedef enum logic [1:0] {
    CMD_SPHERE = 2'd0,
    CMD_BOX    = 2'd1,
    CMD_PLANE  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // Squared length fits in 68 bits; its floor square root fits in 36.
  localparam int unsigned SQ_W  = 68;
  localparam int unsigned LEN_W = 36;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] sphere_x;
    logic signed [31:0] sphere_y;
    logic signed [31:0] sphere_z;
    logic [30:0]        sphere_radius;
    logic signed [31:0] vec_a_x;
    logic signed [31:0] vec_a_y;
    logic signed [31:0] vec_a_z;
    logic signed [31:0] vec_b_x;
    logic signed [31:0] vec_b_y;
    logic signed [31:0] vec_b_z;
    logic signed [31:0] other_scalar;
  } in_item_t;

  typedef struct packed {
    logic               is_colliding;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] penetration;
    logic signed [31:0] contact_a_x;
    logic signed [31:0] contact_a_y;
    logic signed [31:0] contact_a_z;
    logic signed [31:0] contact_b_x;
    logic signed [31:0] contact_b_y;
    logic signed [31:0] contact_b_z;
  } out_item_t;

  // Side information that travels with an item through the root and divide stages.
  typedef struct packed {
    cmd_e              cmd;
    logic [30:0]       rad;
    logic [31:0]       oth;
    logic [2:0]        dneg;
    logic [2:0][32:0]  dmag;
    logic [2:0][31:0]  nrm;
    logic              in_box;
    logic              pl_hit;
    logic [31:0]       pl_pen;
  } meta_t;

  function automatic logic [31:0] sat32(input logic signed [71:0] v);
    logic [31:0] r;
    if (v > 72'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -72'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/scol_front.sv]
`default_nettype none
module scol_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire scol_pkg::in_item_t   item_i,
  output logic                      valid_o,
  output logic [scol_pkg::SQ_W-1:0] sum_o,
  output scol_pkg::meta_t           meta_o
);
  import scol_pkg::*;

  logic     v0_q, v1_q, v2_q, v3_q;
  in_item_t it_q;

  logic [2:0][32:0]          vec_d, vec_q;
  logic signed [63:0]        pr_d [3];
  logic signed [63:0]        pr_q [3];
  meta_t                     m1_d, m1_q, m2_q, m3_d, m3_q;
  logic [65:0]               sq_d [3];
  logic [65:0]               sq_q [3];
  logic signed [65:0]        ps_d, ps_q;
  logic [SQ_W-1:0]           sum_d, sum_q;

  always_comb begin
    logic signed [31:0] cv [3];
    logic signed [31:0] av [3];
    logic signed [31:0] bv [3];
    logic signed [32:0] da, db, hs;
    logic [32:0]        dam, dbm;
    logic signed [33:0] ctr;
    cv[0] = it_q.sphere_x; cv[1] = it_q.sphere_y; cv[2] = it_q.sphere_z;
    av[0] = it_q.vec_a_x;  av[1] = it_q.vec_a_y;  av[2] = it_q.vec_a_z;
    bv[0] = it_q.vec_b_x;  bv[1] = it_q.vec_b_y;  bv[2] = it_q.vec_b_z;
    m1_d        = '0;
    m1_d.cmd    = cmd_e'(it_q.command);
    m1_d.rad    = it_q.sphere_radius;
    m1_d.oth    = it_q.other_scalar;
    m1_d.in_box = 1'b1;
    for (int i = 0; i < 3; i++) begin
      da  = 33'(av[i]) - 33'(cv[i]);
      db  = 33'(bv[i]) - 33'(cv[i]);
      dam = da[32] ? 33'(-da) : da;
      dbm = db[32] ? 33'(-db) : db;
      hs  = (33'(av[i]) + 33'(bv[i])) >>> 1;
      ctr = 34'(hs) - 34'(cv[i]);
      m1_d.dmag[i] = dam;
      m1_d.dneg[i] = da[32];
      if (!((cv[i] > av[i]) && (cv[i] < bv[i]))) begin
        m1_d.in_box = 1'b0;
      end
      case (cmd_e'(it_q.command))
        CMD_BOX: begin
          vec_d[i]    = (dam < dbm) ? dam : dbm;
          m1_d.nrm[i] = sat32(72'(ctr));
        end
        CMD_PLANE: begin
          vec_d[i]    = dam;
          m1_d.nrm[i] = av[i];
        end
        default: begin
          vec_d[i]    = dam;
          m1_d.nrm[i] = '0;
        end
      endcase
      pr_d[i] = 64'(cv[i]) * 64'(av[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = 66'(vec_q[i]) * 66'(vec_q[i]);
    end
    ps_d = 66'(pr_q[0]) + 66'(pr_q[1]) + 66'(pr_q[2]);
  end

  always_comb begin
    logic signed [66:0] s;
    logic [66:0]        sa;
    logic signed [67:0] q;
    logic [67:0]        qa;
    sum_d = SQ_W'(sq_q[0]) + SQ_W'(sq_q[1]) + SQ_W'(sq_q[2]);
    s     = 67'(ps_q >>> FRAC_BITS) - 67'($signed(m2_q.oth));
    sa    = s[66] ? 67'(-s) : 67'(s);
    q     = $signed({1'b0, sa}) - $signed({37'b0, m2_q.rad});
    qa    = q[67] ? 68'(-q) : 68'(q);
    m3_d        = m2_q;
    m3_d.pl_hit = q[67];
    m3_d.pl_pen = sat32($signed({4'b0, qa}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q  <= item_i;
    vec_q <= vec_d;
    pr_q  <= pr_d;
    m1_q  <= m1_d;
    sq_q  <= sq_d;
    ps_q  <= ps_d;
    m2_q  <= m1_q;
    sum_q <= sum_d;
    m3_q  <= m3_d;
  end

  assign valid_o = v3_q;
  assign sum_o   = sum_q;
  assign meta_o  = m3_q;

endmodule
`default_nettype wire

[hw/rtl/scol_sqrt.sv]
`default_nettype none
module scol_sqrt (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  input  wire logic [scol_pkg::SQ_W-1:0] sum_i,
  input  wire scol_pkg::meta_t       meta_i,
  output logic                       valid_o,
  output logic [scol_pkg::LEN_W-1:0] root_o,
  output scol_pkg::meta_t            meta_o
);
  import scol_pkg::*;

  // One result bit per stage, most significant first; the running square is kept
  // so that each stage needs only adds and one compare.
  logic              vl [LEN_W+1];
  logic [LEN_W-1:0]  rt [LEN_W+1];
  logic [2*LEN_W-1:0] r2 [LEN_W+1];
  logic [SQ_W-1:0]   sm [LEN_W+1];
  meta_t             mt [LEN_W+1];

  assign vl[0] = valid_i;
  assign rt[0] = '0;
  assign r2[0] = '0;
  assign sm[0] = sum_i;
  assign mt[0] = meta_i;

  for (genvar g = 0; g < LEN_W; g++) begin : g_stage
    localparam int unsigned B = LEN_W - 1 - g;
    logic [2*LEN_W+1:0] cand;
    logic               take;
    assign cand = (2*LEN_W+2)'(r2[g]) + ((2*LEN_W+2)'(rt[g]) << (B + 1))
                + ((2*LEN_W+2)'(1) << (2 * B));
    assign take = cand <= (2*LEN_W+2)'(sm[g]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vl[g+1] <= 1'b0;
      end else begin
        vl[g+1] <= vl[g];
      end
    end

    always_ff @(posedge clk_i) begin
      rt[g+1] <= take ? (rt[g] | (LEN_W'(1) << B)) : rt[g];
      r2[g+1] <= take ? cand[2*LEN_W-1:0] : r2[g];
      sm[g+1] <= sm[g];
      mt[g+1] <= mt[g];
    end
  end

  assign valid_o = vl[LEN_W];
  assign root_o  = rt[LEN_W];
  assign meta_o  = mt[LEN_W];

endmodule
`default_nettype wire

[hw/rtl/scol_div.sv]
`default_nettype none
module scol_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  input  wire logic [scol_pkg::LEN_W-1:0] len_i,
  input  wire scol_pkg::meta_t       meta_i,
  output logic                       valid_o,
  output logic [2:0][FRAC_BITS:0]    quo_o,
  output logic [scol_pkg::LEN_W-1:0] len_o,
  output scol_pkg::meta_t            meta_o
);
  import scol_pkg::*;

  // Each axis component is at most the length, so the quotient needs FRAC_BITS+1 bits:
  // one restoring step per quotient bit, three lanes side by side.
  localparam int unsigned NS = FRAC_BITS + 1;
  localparam int unsigned RW = LEN_W + FRAC_BITS + 1;

  logic                 vl [NS+1];
  logic [2:0][RW-1:0]   rm [NS+1];
  logic [2:0][NS-1:0]   qt [NS+1];
  logic [LEN_W-1:0]     ln [NS+1];
  meta_t                mt [NS+1];

  assign vl[0] = valid_i;
  assign ln[0] = len_i;
  assign mt[0] = meta_i;
  assign qt[0] = '0;
  for (genvar l = 0; l < 3; l++) begin : g_init
    assign rm[0][l] = RW'(meta_i.dmag[l]) << FRAC_BITS;
  end

  for (genvar g = 0; g < NS; g++) begin : g_stage
    localparam int unsigned K = NS - 1 - g;
    logic [RW-1:0]      dv;
    logic [2:0][RW-1:0] rm_d;
    logic [2:0][NS-1:0] qt_d;
    assign dv = RW'(ln[g]) << K;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if (rm[g][l] >= dv) begin
          rm_d[l] = rm[g][l] - dv;
          qt_d[l] = qt[g][l] | (NS'(1) << K);
        end else begin
          rm_d[l] = rm[g][l];
          qt_d[l] = qt[g][l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vl[g+1] <= 1'b0;
      end else begin
        vl[g+1] <= vl[g];
      end
    end

    always_ff @(posedge clk_i) begin
      rm[g+1] <= rm_d;
      qt[g+1] <= qt_d;
      ln[g+1] <= ln[g];
      mt[g+1] <= mt[g];
    end
  end

  assign valid_o = vl[NS];
  assign quo_o   = qt[NS];
  assign len_o   = ln[NS];
  assign meta_o  = mt[NS];

endmodule
`default_nettype wire

[hw/rtl/scol_back.sv]
`default_nettype none
module scol_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  input  wire logic [2:0][FRAC_BITS:0] quo_i,
  input  wire logic [scol_pkg::LEN_W-1:0] len_i,
  input  wire scol_pkg::meta_t       meta_i,
  output logic                       valid_o,
  output scol_pkg::out_item_t        result_o
);
  import scol_pkg::*;

  localparam int unsigned PW = 37 + FRAC_BITS + 1;

  logic                     v1_q, v2_q, v3_q;
  meta_t                    m1_q, m2_q;
  logic [2:0][FRAC_BITS:0]  nm_d, nm_q, nm2_q;
  logic [LEN_W-1:0]         ln_q, ln2_q;
  logic signed [37:0]       pen_d, pen_q, pen2_q;
  logic [36:0]              ka_d, ka_q, kb_d, kb_q;
  logic                     kan_d, kan_q, kbn_d, kbn_q, hit_d, hit_q, hit2_q;
  logic [2:0][PW-1:0]       pa_d, pa_q, pb_d, pb_q;
  logic                     kan2_q, kbn2_q;
  out_item_t                res_d, res_q;

  always_comb begin
    logic signed [37:0] ls, rs, os, ka, kb;
    ls = $signed({2'b0, len_i});
    rs = $signed({7'b0, meta_i.rad});
    os = 38'($signed(meta_i.oth));
    for (int i = 0; i < 3; i++) begin
      nm_d[i] = (len_i == '0) ? '0 : quo_i[i];
    end
    pen_d = rs + os - ls;
    ka    = ls - os;
    kb    = ls - rs;
    kan_d = ka[37];
    kbn_d = kb[37];
    ka_d  = ka[37] ? 37'(-ka) : 37'(ka);
    kb_d  = kb[37] ? 37'(-kb) : 37'(kb);
    hit_d = ls < rs + os;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa_d[i] = PW'(ka_q) * PW'(nm_q[i]);
      pb_d[i] = PW'(kb_q) * PW'(nm_q[i]);
    end
  end

  always_comb begin
    logic signed [FRAC_BITS+1:0] ns;
    logic signed [PW:0]          ca, cb;
    logic [31:0]                 nx [3];
    logic [31:0]                 cax [3];
    logic [31:0]                 cbx [3];
    for (int i = 0; i < 3; i++) begin
      ns = $signed({1'b0, nm2_q[i]});
      ns = m2_q.dneg[i] ? -ns : ns;
      nx[i] = sat32(72'(ns));
      ca = $signed({1'b0, pa_q[i] >> FRAC_BITS});
      cb = $signed({1'b0, pb_q[i] >> FRAC_BITS});
      ca = (kan2_q ^ m2_q.dneg[i]) ? -ca : ca;
      cb = (kbn2_q ^ m2_q.dneg[i]) ? -cb : cb;
      cax[i] = sat32(72'(ca));
      cbx[i] = sat32(72'(cb));
    end
    res_d = '0;
    case (m2_q.cmd)
      CMD_SPHERE: begin
        res_d.is_colliding = hit2_q;
        res_d.normal_x     = nx[0];
        res_d.normal_y     = nx[1];
        res_d.normal_z     = nx[2];
        res_d.penetration  = sat32(72'(pen2_q));
        res_d.contact_a_x  = cax[0];
        res_d.contact_a_y  = cax[1];
        res_d.contact_a_z  = cax[2];
        res_d.contact_b_x  = cbx[0];
        res_d.contact_b_y  = cbx[1];
        res_d.contact_b_z  = cbx[2];
      end
      CMD_BOX: begin
        res_d.normal_x = m2_q.nrm[0];
        res_d.normal_y = m2_q.nrm[1];
        res_d.normal_z = m2_q.nrm[2];
        if (m2_q.in_box) begin
          res_d.is_colliding = 1'b1;
          res_d.penetration  = sat32($signed({36'b0, ln2_q}));
        end else begin
          res_d.is_colliding = LEN_W'(m2_q.rad) > ln2_q;
          res_d.penetration  = sat32(72'($signed({6'b0, m2_q.rad}) - $signed({1'b0, ln2_q})));
        end
      end
      CMD_PLANE: begin
        res_d.is_colliding = m2_q.pl_hit;
        res_d.normal_x     = m2_q.nrm[0];
        res_d.normal_y     = m2_q.nrm[1];
        res_d.normal_z     = m2_q.nrm[2];
        res_d.penetration  = m2_q.pl_pen;
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_q   <= meta_i;
    nm_q   <= nm_d;
    ln_q   <= len_i;
    pen_q  <= pen_d;
    ka_q   <= ka_d;
    kb_q   <= kb_d;
    kan_q  <= kan_d;
    kbn_q  <= kbn_d;
    hit_q  <= hit_d;
    m2_q   <= m1_q;
    nm2_q  <= nm_q;
    ln2_q  <= ln_q;
    pen2_q <= pen_q;
    hit2_q <= hit_q;
    kan2_q <= kan_q;
    kbn2_q <= kbn_q;
    pa_q   <= pa_d;
    pb_q   <= pb_d;
    res_q  <= res_d;
  end

  assign valid_o  = v3_q;
  assign result_o = res_q;

  a_contact_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && m2_q.cmd != CMD_SPHERE) |=>
      (res_q.contact_a_x == '0 && res_q.contact_a_y == '0 && res_q.contact_a_z == '0 &&
       res_q.contact_b_x == '0 && res_q.contact_b_y == '0 && res_q.contact_b_z == '0))
    else $error("contact offset nonzero outside sphere pair");

  a_plane_pen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && m2_q.cmd == CMD_PLANE) |=> !res_q.penetration[31])
    else $error("plane penetration negative");

  a_box_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && m2_q.cmd == CMD_BOX && m2_q.in_box) |=> res_q.is_colliding)
    else $error("center inside box but no collision");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && m2_q.cmd == CMD_NONE) |=> (res_q == '0))
    else $error("unused command gave a nonzero result");

endmodule
`default_nettype wire

[hw/rtl/sphere_collision_test.sv]
// Channel   Ports                      Direction  Handshake
// query     start, busy, item_i        in         taken when start is high and busy low
// result    valid_o, result_o          out        shown for one cycle, no back-pressure
//
// Every item passes from acceptance to its result strobe through four front
// stages, 36 square-root stages (one root bit each), FRAC_BITS+1 divide
// stages (one quotient bit each) and three output stages.
// One item can be accepted in every cycle; busy is always low, since the
// pipeline never stalls and the receiver takes every result as it appears.
// Reset clears only the valid bits that travel with the items.
`default_nettype none
module sphere_collision_test #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire scol_pkg::in_item_t  item_i,
  output logic                     valid_o,
  output scol_pkg::out_item_t      result_o
);
  import scol_pkg::*;

  // Front end: differences, box nearest-face distances and the plane dot product,
  // then squares, the squared length and the plane hit and penetration.
  logic            fr_valid;
  logic [SQ_W-1:0] fr_sum;
  meta_t           fr_meta;

  // The shared length unit serves both the sphere distance and the box distance.
  logic             sq_valid;
  logic [LEN_W-1:0] sq_root;
  meta_t            sq_meta;

  // Normalization of the sphere direction: one quotient per axis.
  logic                    dv_valid;
  logic [2:0][FRAC_BITS:0] dv_quo;
  logic [LEN_W-1:0]        dv_len;
  meta_t                   dv_meta;

  assign busy = 1'b0;

  scol_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .item_i  (item_i),
    .valid_o (fr_valid),
    .sum_o   (fr_sum),
    .meta_o  (fr_meta)
  );

  scol_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .sum_i   (fr_sum),
    .meta_i  (fr_meta),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .meta_o  (sq_meta)
  );

  scol_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .len_i   (sq_root),
    .meta_i  (sq_meta),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .len_o   (dv_len),
    .meta_o  (dv_meta)
  );

  // Back end: penetration, contact offsets and the per-command result select.
  scol_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (dv_valid),
    .quo_i    (dv_quo),
    .len_i    (dv_len),
    .meta_i   (dv_meta),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

endmodule
`default_nettype wire

[bench/collision_checker.sv]
module collision_checker (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  input  wire logic                busy,
  input  wire scol_pkg::in_item_t  item_i,
  input  wire logic                valid_o,
  input  wire scol_pkg::out_item_t result_o,
  output int                       n_fail_o,
  output int                       n_pending_o
);
  import scol_pkg::*;

  localparam int FB = 16;

  out_item_t expected_q[$];

  function automatic logic [31:0] clamp32(input logic signed [127:0] v);
    logic [31:0] r;
    if (v > 128'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -128'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [127:0] mag(input logic signed [127:0] v);
    return v < 0 ? -v : v;
  endfunction

  // Floor of the Euclidean length, found bit by bit.
  function automatic logic signed [127:0] vec_len(input logic signed [127:0] x,
                                                  input logic signed [127:0] y,
                                                  input logic signed [127:0] z);
    logic [127:0] s;
    logic [127:0] r;
    logic [127:0] c;
    s = mag(x) * mag(x) + mag(y) * mag(y) + mag(z) * mag(z);
    r = 0;
    for (int b = 35; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= s) r = c;
    end
    return $signed(r);
  endfunction

  // Product scaled down, truncated toward zero.
  function automatic logic signed [127:0] scaled_mul(input logic signed [127:0] a,
                                                     input logic signed [127:0] b);
    logic signed [127:0] m;
    m = (mag(a) * mag(b)) >>> FB;
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  function automatic out_item_t predict_contact(input in_item_t q);
    out_item_t r;
    logic signed [127:0] c[3], a[3], b[3], d[3], n[3], m[3];
    logic signed [127:0] rad, oth, len, pen, s, box_len, d1, d2;
    logic in_box;
    r = '0;
    rad = q.sphere_radius;
    oth = q.other_scalar;
    c[0] = q.sphere_x; c[1] = q.sphere_y; c[2] = q.sphere_z;
    a[0] = q.vec_a_x;  a[1] = q.vec_a_y;  a[2] = q.vec_a_z;
    b[0] = q.vec_b_x;  b[1] = q.vec_b_y;  b[2] = q.vec_b_z;
    case (cmd_e'(q.command))
      CMD_SPHERE: begin
        for (int i = 0; i < 3; i++) d[i] = a[i] - c[i];
        len = vec_len(d[0], d[1], d[2]);
        for (int i = 0; i < 3; i++) begin
          if (len == 0) n[i] = 0;
          else begin
            n[i] = (mag(d[i]) <<< FB) / len;
            if (d[i] < 0) n[i] = -n[i];
          end
        end
        pen = rad + oth - len;
        r.is_colliding = len < rad + oth;
        r.normal_x = clamp32(n[0]);
        r.normal_y = clamp32(n[1]);
        r.normal_z = clamp32(n[2]);
        r.penetration = clamp32(pen);
        r.contact_a_x = clamp32(scaled_mul(rad - pen, n[0]));
        r.contact_a_y = clamp32(scaled_mul(rad - pen, n[1]));
        r.contact_a_z = clamp32(scaled_mul(rad - pen, n[2]));
        r.contact_b_x = clamp32(scaled_mul(oth - pen, n[0]));
        r.contact_b_y = clamp32(scaled_mul(oth - pen, n[1]));
        r.contact_b_z = clamp32(scaled_mul(oth - pen, n[2]));
      end
      CMD_BOX: begin
        in_box = 1'b1;
        for (int i = 0; i < 3; i++) begin
          d1 = mag(a[i] - c[i]);
          d2 = mag(b[i] - c[i]);
          m[i] = d1 < d2 ? d1 : d2;
          n[i] = ((a[i] + b[i]) >>> 1) - c[i];
          if (!(c[i] > a[i] && c[i] < b[i])) in_box = 1'b0;
        end
        r.normal_x = clamp32(n[0]);
        r.normal_y = clamp32(n[1]);
        r.normal_z = clamp32(n[2]);
        box_len = vec_len(m[0], m[1], m[2]);
        if (in_box) begin
          r.is_colliding = 1'b1;
          r.penetration = clamp32(box_len);
        end else begin
          r.is_colliding = rad > box_len;
          r.penetration = clamp32(rad - box_len);
        end
      end
      CMD_PLANE: begin
        s = ((c[0] * a[0] + c[1] * a[1] + c[2] * a[2]) >>> FB) - oth;
        s = mag(s) - rad;
        r.is_colliding = s < 0;
        r.penetration = clamp32(mag(s));
        r.normal_x = q.vec_a_x;
        r.normal_y = q.vec_a_y;
        r.normal_z = q.vec_a_z;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  assign n_pending_o = expected_q.size();

  initial n_fail_o = 0;

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (valid_o) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, result_o);
          n_fail_o <= n_fail_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== result_o) begin
            $display("%0t: mismatch, expected %h, actual %h", $time, want, result_o);
            n_fail_o <= n_fail_o + 1;
          end
        end
      end
      if (start && !busy) expected_q.push_back(predict_contact(item_i));
    end
  end
endmodule

[bench/tb.sv]
module tb;
  import scol_pkg::*;

  localparam int LATENCY = 60;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  in_item_t  item_i;
  logic      valid_o;
  out_item_t result_o;
  int        n_fail;
  int        n_pending;

  sphere_collision_test i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .valid_o (valid_o),
    .result_o(result_o)
  );

  collision_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .valid_o    (valid_o),
    .result_o   (result_o),
    .n_fail_o   (n_fail),
    .n_pending_o(n_pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // A coordinate that is mostly extreme or small, so that saturation and
  // ordinary geometry are both exercised.
  function automatic logic [31:0] pick_coord();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom();
      1: v = $urandom_range(0, 3) == 0 ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: v = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endcase
    return v;
  endfunction

  function automatic in_item_t random_query();
    in_item_t q;
    logic [31:0] lo, hi;
    q.command = $urandom_range(0, 15) == 0 ? CMD_NONE : cmd_e'($urandom_range(0, 2));
    q.sphere_x = pick_coord();
    q.sphere_y = pick_coord();
    q.sphere_z = pick_coord();
    q.sphere_radius = $urandom_range(0, 3) == 0 ? 31'($urandom())
                                                : 31'($urandom_range(0, 32'h0008_0000));
    q.vec_a_x = pick_coord();
    q.vec_a_y = pick_coord();
    q.vec_a_z = pick_coord();
    q.vec_b_x = pick_coord();
    q.vec_b_y = pick_coord();
    q.vec_b_z = pick_coord();
    q.other_scalar = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h0008_0000);
    // Most boxes are well-formed and placed around the sphere so that the
    // inside and near-face cases come up often.
    if (q.command == CMD_BOX && $urandom_range(0, 3) != 0) begin
      lo = $urandom_range(0, 32'h0004_0000);
      hi = $urandom_range(0, 32'h0004_0000);
      q.sphere_x = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
      q.vec_a_x = q.sphere_x - $signed(lo);
      q.vec_b_x = q.sphere_x + $signed(hi);
      q.vec_a_y = q.sphere_y - $signed($urandom_range(0, 32'h0004_0000));
      q.vec_b_y = q.sphere_y + $signed($urandom_range(0, 32'h0004_0000));
      q.vec_a_z = q.sphere_z - $signed($urandom_range(0, 32'h0004_0000));
      q.vec_b_z = q.sphere_z + $signed($urandom_range(0, 32'h0004_0000));
    end
    // Most sphere pairs are placed near each other, so that hits come up often.
    if (q.command == CMD_SPHERE && $urandom_range(0, 2) != 0) begin
      q.vec_a_x = q.sphere_x + ($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      q.vec_a_y = q.sphere_y + ($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      q.vec_a_z = q.sphere_z + ($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
    end
    return q;
  endfunction

  // Presents one item at the falling edge and waits until it is accepted,
  // after an idle gap drawn for this item. The gap is sometimes zero so that
  // back-to-back streams occur. Start stays high after acceptance so that a
  // following item with no gap keeps the stream unbroken; the caller drops it.
  task automatic send_query(input in_item_t q);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    item_i <= q;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_burst(input in_item_t q);
    start <= 1'b1;
    item_i <= q;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    in_item_t q;
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: extremes of every field and each special case.
    q = '0;
    send_query(q);                      // coincident sphere centers, zero normal
    q.command = CMD_SPHERE;
    q.sphere_radius = 31'h7FFF_FFFF;
    q.other_scalar = 32'h7FFF_FFFF;
    q.vec_a_x = 32'h0001_0000;
    send_query(q);                      // penetration saturates high
    q.sphere_x = 32'h8000_0000; q.sphere_y = 32'h8000_0000; q.sphere_z = 32'h8000_0000;
    q.vec_a_x = 32'h7FFF_FFFF; q.vec_a_y = 32'h7FFF_FFFF; q.vec_a_z = 32'h7FFF_FFFF;
    q.other_scalar = 32'h8000_0000;
    q.sphere_radius = '0;
    send_query(q);                      // widest possible separation
    q.sphere_radius = 31'h7FFF_FFFF;
    q.other_scalar = 32'h7FFF_FFFF;
    send_query(q);
    q = '0;
    q.command = CMD_SPHERE;
    q.vec_a_y = 32'h0002_0000;
    q.sphere_radius = 31'h0001_0000;
    q.other_scalar = 32'h0001_0000;
    send_query(q);                      // spheres just touching
    q.command = CMD_BOX;
    q.vec_a_x = -32'sh0001_0000; q.vec_a_y = -32'sh0001_0000; q.vec_a_z = -32'sh0001_0000;
    q.vec_b_x = 32'h0001_0000; q.vec_b_y = 32'h0001_0000; q.vec_b_z = 32'h0001_0000;
    send_query(q);                      // center strictly inside the box
    q.sphere_x = 32'h0001_0000;
    send_query(q);                      // center on a face
    q.vec_a_x = 32'h0001_0000; q.vec_b_x = -32'sh0001_0000;
    send_query(q);                      // inverted box
    q.vec_a_x = 32'h8000_0000; q.vec_a_y = 32'h8000_0000; q.vec_a_z = 32'h8000_0000;
    q.vec_b_x = 32'h7FFF_FFFF; q.vec_b_y = 32'h7FFF_FFFF; q.vec_b_z = 32'h7FFF_FFFF;
    q.sphere_radius = 31'h7FFF_FFFF;
    send_query(q);                      // largest box
    q.vec_a_x = 32'h7FFF_FFFF; q.vec_b_x = 32'h7FFF_FFFF;
    q.sphere_x = 32'h8000_0000; q.sphere_radius = '0;
    send_query(q);                      // far outside, normal saturates
    q = '0;
    q.command = CMD_PLANE;
    q.vec_a_z = 32'h0001_0000;
    q.sphere_z = 32'h0000_8000;
    q.sphere_radius = 31'h0001_0000;
    send_query(q);                      // plane hit
    q.sphere_z = -32'sh0003_0000;
    send_query(q);                      // plane miss below
    q.sphere_x = 32'h8000_0000; q.sphere_y = 32'h8000_0000; q.sphere_z = 32'h8000_0000;
    q.vec_a_x = 32'h8000_0000; q.vec_a_y = 32'h8000_0000; q.vec_a_z = 32'h8000_0000;
    q.other_scalar = 32'h8000_0000;
    send_query(q);                      // largest dot product
    q.vec_a_x = 32'h7FFF_FFFF; q.other_scalar = 32'h7FFF_FFFF;
    q.sphere_radius = 31'h7FFF_FFFF;
    send_query(q);
    q.command = CMD_NONE;
    send_query(q);                      // unused command gives all zeros
    q = '1;
    q.command = CMD_NONE;
    send_query(q);
    start <= 1'b0;

    // Hold off until the pipeline has drained completely.
    while (n_pending != 0) @(negedge clk_i);

    for (int k = 0; k < 460; k++) begin
      if (k % 100 == 50) begin
        // A back-to-back burst with no gaps.
        for (int j = 0; j < 40; j++) send_burst(random_query());
      end else begin
        send_query(random_query());
      end
    end
    start <= 1'b0;

    while (n_pending != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    if (n_fail == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
